>>> design/mono_legato_note_priority_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the mono / legato note priority block
// Concurrent check wrappers clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MONO_LEGATO_NOTE_PRIORITY_DEFINES_SVH
`define MONO_LEGATO_NOTE_PRIORITY_DEFINES_SVH

`ifndef SYNTH
// Check a condition at every clock edge.
`define MLNP_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("mlnp check failed");
// Check a consequence in the cycle after a trigger.
`define MLNP_ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("mlnp sequence check failed");
`else
`define MLNP_ASSERT_ALWAYS(label, cond)
`define MLNP_ASSERT_NEXT(label, trig, cons)
`endif

`endif

>>> design/mlnp_pkg.sv
// ----------------------------------------------------------------------------
// mlnp_pkg
// Shared types and constants of the note priority block.
// ----------------------------------------------------------------------------
`default_nettype none

package mlnp_pkg;

    localparam int unsigned STACK_DEPTH_DEF = 16;
    localparam int unsigned NOTE_W          = 7;
    localparam int unsigned VEL_W           = 7;
    localparam int unsigned CHAN_W          = 4;
    localparam int unsigned OP_W            = 2;
    localparam int unsigned ACT_W           = 2;
    localparam int unsigned MODE_W          = 2;

    localparam logic [VEL_W-1:0] RETRIG_VEL = VEL_W'(64);

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_OTHER    = 2'd2,
        OP_RSVD     = 2'd3
    } op_t;

    typedef enum logic [ACT_W-1:0] {
        ACT_PASS     = 2'd0,
        ACT_NOTE_OFF = 2'd1,
        ACT_NOTE_ON  = 2'd2,
        ACT_GLIDE    = 2'd3
    } action_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_POLY   = 2'd0,
        MODE_MONO   = 2'd1,
        MODE_LEGATO = 2'd2,
        MODE_MONO_X = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_MATCH,
        CELL_COMPACT,
        CELL_PUSH,
        CELL_CLEAR
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [NOTE_W-1:0]   key;
    } cell_cmd_t;

endpackage

`default_nettype wire

>>> design/mlnp_cell.sv
// ----------------------------------------------------------------------------
// mlnp_cell
// One slot of the held-note stack: compare, close a gap, or shift on push.
// ----------------------------------------------------------------------------
`default_nettype none

module mlnp_cell #(
    parameter int unsigned IDX   = 0,
    parameter int unsigned CNT_W = 5
) (
    input  wire logic                        aclk,
    input  wire mlnp_pkg::cell_cmd_t         cmd,
    input  wire logic [CNT_W-1:0]            count,
    input  wire logic [mlnp_pkg::NOTE_W-1:0] note_above,
    input  wire logic [mlnp_pkg::NOTE_W-1:0] note_below,
    input  wire logic                        hit_prefix,
    output logic [mlnp_pkg::NOTE_W-1:0]      note,
    output logic                             match
);
    import mlnp_pkg::*;

    logic [NOTE_W-1:0] note_reg;
    logic              match_reg;

    // Slot 0 holds the newest note; higher slots hold older ones.
    always_ff @(posedge aclk) begin
        case (cmd.op)
            CELL_MATCH: begin
                match_reg <= (note_reg == cmd.key) && (count > CNT_W'(IDX));
            end
            CELL_COMPACT: begin
                // close the gap left by a matching slot at or below this one
                if (hit_prefix) begin
                    note_reg <= note_above;
                end
            end
            CELL_PUSH: begin
                note_reg <= note_below;
            end
            default: begin
                note_reg <= note_reg;
            end
        endcase
    end

    assign note  = note_reg;
    assign match = match_reg;

endmodule

`default_nettype wire

>>> design/mlnp_stack.sv
// ----------------------------------------------------------------------------
// mlnp_stack
// Row of note cells with a registered match vector and the fill count.
// ----------------------------------------------------------------------------
`default_nettype none

module mlnp_stack #(
    parameter int unsigned STACK_DEPTH = mlnp_pkg::STACK_DEPTH_DEF,
    localparam int unsigned CNT_W      = $clog2(STACK_DEPTH + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire mlnp_pkg::cell_cmd_t         cmd,
    output logic [CNT_W-1:0]                 count,
    output logic [mlnp_pkg::NOTE_W-1:0]      top_note
);
    import mlnp_pkg::*;

    localparam int unsigned LVL = $clog2(STACK_DEPTH);

    logic [NOTE_W-1:0]      cell_note [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] match_vec;
    logic [STACK_DEPTH-1:0] pre [LVL+1];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    // Parallel prefix OR: pre[LVL][i] is set when any slot 0..i matched.
    assign pre[0] = match_vec;
    for (genvar k = 0; k < LVL; k++) begin : g_lvl
        for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_bit
            if (i >= (1 << k)) begin : g_or
                assign pre[k+1][i] = pre[k][i] | pre[k][i - (1 << k)];
            end else begin : g_cp
                assign pre[k+1][i] = pre[k][i];
            end
        end
    end

    for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
        logic [NOTE_W-1:0] above;
        logic [NOTE_W-1:0] below;
        if (i == STACK_DEPTH - 1) begin : g_last
            assign above = cell_note[i];
        end else begin : g_mid
            assign above = cell_note[i+1];
        end
        if (i == 0) begin : g_first
            assign below = cmd.key;
        end else begin : g_rest
            assign below = cell_note[i-1];
        end

        mlnp_cell #(
            .IDX   (i),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cmd),
            .count      (count_reg),
            .note_above (above),
            .note_below (below),
            .hit_prefix (pre[LVL][i]),
            .note       (cell_note[i]),
            .match      (match_vec[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        case (cmd.op)
            CELL_COMPACT: begin
                if (pre[LVL][STACK_DEPTH-1]) begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            CELL_PUSH: begin
                // a full stack drops its oldest slot off the far end
                if (count_reg != CNT_W'(STACK_DEPTH)) begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            CELL_CLEAR: begin
                count_next = '0;
            end
            default: begin
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count    = count_reg;
    assign top_note = cell_note[0];

endmodule

`default_nettype wire

>>> design/mono_legato_note_priority.sv
// ----------------------------------------------------------------------------
// mono_legato_note_priority
// Last-note-priority mono / legato filter for a stream of note events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one note event per transaction (operation, channel,
//   note, velocity). Result channel m_*: zero, one or two result transactions
//   per event; m_last marks the final one. cfg_wr_en writes voice_mode
//   (0 poly, 1 mono, 2 legato, 3 mono) and takes effect at once; write it
//   only while no event is in flight.
//   Poly mode and other messages go straight to the decision; a note off
//   first passes match and gap close, a note on also push. A note off
//   that is discarded frees the block with no result.
//   One event is in flight at a time; the sequencer steps it through match,
//   gap close and push over the cell row, and a new event is taken only
//   once the last one is through, including a stolen note's extra result.
//   The stolen note-off and the following pass wait in the output register
//   for the receiver; while m_ready is low the sequencer holds and s_ready
//   stays low once the next event needs the output.
//   Reset (aresetn low, synchronous) empties the stack count, clears the
//   sounding note and sets poly mode. Stack slots are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "mono_legato_note_priority_defines.svh"

module mono_legato_note_priority #(
    parameter int unsigned STACK_DEPTH = mlnp_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        cfg_wr_en,
    input  wire logic [mlnp_pkg::MODE_W-1:0] cfg_wr_data,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [mlnp_pkg::OP_W-1:0]   s_operation,
    input  wire logic [mlnp_pkg::CHAN_W-1:0] s_channel,
    input  wire logic [mlnp_pkg::NOTE_W-1:0] s_note,
    input  wire logic [mlnp_pkg::VEL_W-1:0]  s_velocity,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [mlnp_pkg::ACT_W-1:0]       m_action,
    output logic [mlnp_pkg::CHAN_W-1:0]      m_out_channel,
    output logic [mlnp_pkg::NOTE_W-1:0]      m_out_note,
    output logic [mlnp_pkg::VEL_W-1:0]       m_out_velocity,
    output logic                             m_last
);
    import mlnp_pkg::*;

    localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MATCH,
        ST_COMPACT,
        ST_PUSH,
        ST_DECIDE,
        ST_SECOND
    } state_t;

    state_t            state_reg;
    logic [MODE_W-1:0] mode_reg;

    // latched event
    op_t               op_reg;
    logic [CHAN_W-1:0] chan_reg;
    logic [NOTE_W-1:0] note_reg;
    logic [VEL_W-1:0]  vel_reg;

    // sounding note
    logic [NOTE_W-1:0] cur_note_reg;
    logic              cur_valid_reg;
    logic [NOTE_W-1:0] cur_note_next;
    logic              cur_valid_next;

    // output register
    logic              m_valid_reg;
    action_t           m_action_reg;
    logic [CHAN_W-1:0] m_chan_reg;
    logic [NOTE_W-1:0] m_note_reg;
    logic [VEL_W-1:0]  m_vel_reg;
    logic              m_last_reg;

    // stack interface
    cell_cmd_t         stack_cmd;
    logic [CNT_W-1:0]  held_count;
    logic [NOTE_W-1:0] top_note;

    // decision for the event in ST_DECIDE
    logic [1:0]        n_res;
    action_t           r1_action;
    logic [NOTE_W-1:0] r1_note;
    logic [VEL_W-1:0]  r1_vel;
    logic              r1_last;

    logic              out_free;
    logic              out_load;
    logic              in_fire;
    logic              is_poly;
    logic              is_legato;

    assign out_free  = !m_valid_reg || m_ready;
    assign in_fire   = s_valid && s_ready;
    assign is_poly   = (mode_reg == MODE_POLY);
    assign is_legato = (mode_reg == MODE_LEGATO);
    assign s_ready   = (state_reg == ST_IDLE);

    // A new result enters the output register this cycle.
    assign out_load  = ((state_reg == ST_DECIDE) && (n_res != 2'd0) && out_free) ||
                       ((state_reg == ST_SECOND) && out_free);

    mlnp_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (stack_cmd),
        .count    (held_count),
        .top_note (top_note)
    );

    // Decide results and the new sounding note from the latched event.
    always_comb begin
        n_res          = 2'd1;
        r1_action      = ACT_PASS;
        r1_note        = note_reg;
        r1_vel         = vel_reg;
        r1_last        = 1'b1;
        cur_note_next  = cur_note_reg;
        cur_valid_next = cur_valid_reg;
        if (is_poly) begin
            cur_note_next  = '0;
            cur_valid_next = 1'b0;
        end else begin
            case (op_reg)
                OP_NOTE_ON: begin
                    cur_note_next  = note_reg;
                    cur_valid_next = 1'b1;
                    if (cur_valid_reg && is_legato) begin
                        r1_action = ACT_GLIDE;
                        r1_vel    = '0;
                    end else if (cur_valid_reg) begin
                        // steal: note off for the sounding note, then pass
                        n_res     = 2'd2;
                        r1_action = ACT_NOTE_OFF;
                        r1_note   = cur_note_reg;
                        r1_vel    = '0;
                        r1_last   = 1'b0;
                    end
                end
                OP_NOTE_OFF: begin
                    if (!cur_valid_reg || note_reg != cur_note_reg) begin
                        n_res = 2'd0;
                    end else if (held_count != '0) begin
                        cur_note_next = top_note;
                        r1_note       = top_note;
                        if (is_legato) begin
                            r1_action = ACT_GLIDE;
                            r1_vel    = '0;
                        end else begin
                            r1_action = ACT_NOTE_ON;
                            r1_vel    = RETRIG_VEL;
                        end
                    end else begin
                        cur_note_next  = '0;
                        cur_valid_next = 1'b0;
                    end
                end
                default: begin
                    n_res = 2'd1;
                end
            endcase
        end
    end

    // Drive the cell row from the sequencer state.
    always_comb begin
        stack_cmd.key = note_reg;
        stack_cmd.op  = CELL_HOLD;
        case (state_reg)
            ST_MATCH:   stack_cmd.op = CELL_MATCH;
            ST_COMPACT: stack_cmd.op = CELL_COMPACT;
            ST_PUSH:    stack_cmd.op = CELL_PUSH;
            ST_DECIDE: begin
                if (is_poly && out_free) begin
                    stack_cmd.op = CELL_CLEAR;
                end
            end
            default:    stack_cmd.op = CELL_HOLD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_POLY;
            cur_note_reg  <= '0;
            cur_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                mode_reg <= cfg_wr_data;
            end
            // drop the shown result once taken unless a new one loads
            if (m_ready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        op_reg   <= op_t'(s_operation);
                        chan_reg <= s_channel;
                        note_reg <= s_note;
                        vel_reg  <= s_velocity;
                        if (is_poly || !(s_operation == OP_NOTE_ON ||
                                         s_operation == OP_NOTE_OFF)) begin
                            state_reg <= ST_DECIDE;
                        end else begin
                            state_reg <= ST_MATCH;
                        end
                    end
                end
                ST_MATCH: begin
                    state_reg <= ST_COMPACT;
                end
                ST_COMPACT: begin
                    state_reg <= (op_reg == OP_NOTE_ON) ? ST_PUSH : ST_DECIDE;
                end
                ST_PUSH: begin
                    state_reg <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (n_res == 2'd0) begin
                        cur_note_reg  <= cur_note_next;
                        cur_valid_reg <= cur_valid_next;
                        state_reg     <= ST_IDLE;
                    end else if (out_free) begin
                        cur_note_reg   <= cur_note_next;
                        cur_valid_reg  <= cur_valid_next;
                        m_valid_reg    <= 1'b1;
                        m_action_reg   <= r1_action;
                        m_chan_reg     <= chan_reg;
                        m_note_reg     <= r1_note;
                        m_vel_reg      <= r1_vel;
                        m_last_reg     <= r1_last;
                        state_reg      <= (n_res == 2'd2) ? ST_SECOND : ST_IDLE;
                    end
                end
                ST_SECOND: begin
                    // follow the stolen note off with the event itself
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_action_reg <= ACT_PASS;
                        m_chan_reg   <= chan_reg;
                        m_note_reg   <= note_reg;
                        m_vel_reg    <= vel_reg;
                        m_last_reg   <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_action       = m_action_reg;
    assign m_out_channel  = m_chan_reg;
    assign m_out_note     = m_note_reg;
    assign m_out_velocity = m_vel_reg;
    assign m_last         = m_last_reg;

    // Checks
    `MLNP_ASSERT_ALWAYS(a_count_bound, held_count <= CNT_W'(STACK_DEPTH))
    `MLNP_ASSERT_ALWAYS(a_cur_clear, cur_valid_reg || cur_note_reg == '0)
    `MLNP_ASSERT_ALWAYS(a_first_of_two, !(m_valid && !m_last) || state_reg == ST_SECOND)
    `MLNP_ASSERT_NEXT(a_accept_busy, in_fire, !s_ready)

endmodule

`default_nettype wire
